### rtl/pac_pkg.sv
// Shared types for the pairwise box collision core.
// Holds the stored entry layout and the job word passed from front to back.
`default_nettype none

package pac_pkg;

  localparam int COORD_W = 22;
  localparam int TAG_W   = 16;
  localparam int INDEX_W = 5;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] bottom;
    logic [TAG_W-1:0]          layer;
    logic [TAG_W-1:0]          mask;
  } entry_t;

  typedef struct packed {
    entry_t ent;
    logic   drop;
  } job_t;

endpackage

`default_nettype wire

### rtl/pac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/pac_front.sv
// Front end: accepts colliders, tracks the frame fill count, builds the box.
// Uses pac_pkg for the job word; pushes into pac_queue.
`default_nettype none

module pac_front
  import pac_pkg::*;
#(
  parameter int MAX_COLLIDERS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             first_of_frame,
  input  wire logic signed [23:0]               pos_x,
  input  wire logic signed [23:0]               pos_y,
  input  wire logic        [15:0]               scale,
  input  wire logic signed [11:0]               offset_x,
  input  wire logic signed [11:0]               offset_y,
  input  wire logic        [11:0]               box_width,
  input  wire logic        [11:0]               box_height,
  input  wire logic        [15:0]               layer,
  input  wire logic        [15:0]               mask,
  input  wire logic                             q_full,
  output logic                                  push,
  output job_t                                  push_job,
  output logic [$clog2(MAX_COLLIDERS)-1:0]      push_index
);

  localparam int AW = $clog2(MAX_COLLIDERS);
  localparam int CW = $clog2(MAX_COLLIDERS + 1);

  logic          accept;
  logic [CW-1:0] count;
  logic [CW-1:0] count_base;
  logic          count_full;

  // stage 1: products
  logic                s1_valid;
  logic signed [23:0]  s1_px, s1_py;
  logic signed [28:0]  s1_prod_x, s1_prod_y;
  logic        [27:0]  s1_sw, s1_sh;
  logic        [15:0]  s1_layer, s1_mask;
  logic                s1_drop;
  logic [AW-1:0]       s1_index;

  // stage 2: center and half size
  logic                       s2_valid;
  logic signed [COORD_W-1:0]  s2_cx, s2_cy;
  logic        [18:0]         s2_hw, s2_hh;
  logic        [15:0]         s2_layer, s2_mask;
  logic                       s2_drop;
  logic [AW-1:0]              s2_index;

  logic signed [29:0] sum_x, sum_y, bias_x, bias_y;
  logic signed [COORD_W-1:0] hw_s, hh_s;

  assign busy       = s1_valid | s2_valid | q_full;
  assign accept     = start & ~busy;
  assign count_base = first_of_frame ? '0 : count;
  assign count_full = (count_base == CW'(MAX_COLLIDERS));

  // Q8 sum, then divide by 256 truncating toward zero
  assign sum_x  = 30'(s1_px) + 30'(s1_prod_x);
  assign sum_y  = 30'(s1_py) + 30'(s1_prod_y);
  assign bias_x = sum_x + (sum_x[29] ? 30'sd255 : 30'sd0);
  assign bias_y = sum_y + (sum_y[29] ? 30'sd255 : 30'sd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      if (accept) begin
        count <= count_full ? count_base : CW'(count_base + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px     <= pos_x;
      s1_py     <= pos_y;
      s1_prod_x <= 29'(offset_x * $signed({1'b0, scale}));
      s1_prod_y <= 29'(offset_y * $signed({1'b0, scale}));
      s1_sw     <= 28'(scale * box_width);
      s1_sh     <= 28'(scale * box_height);
      s1_layer  <= layer;
      s1_mask   <= mask;
      s1_drop   <= count_full;
      s1_index  <= AW'(count_base);
    end
    if (s1_valid) begin
      s2_cx    <= bias_x[29:8];
      s2_cy    <= bias_y[29:8];
      // trunc(s*w/256)/2 is s*w/512 for nonnegative values
      s2_hw    <= s1_sw[27:9];
      s2_hh    <= s1_sh[27:9];
      s2_layer <= s1_layer;
      s2_mask  <= s1_mask;
      s2_drop  <= s1_drop;
      s2_index <= s1_index;
    end
  end

  assign hw_s = $signed({3'b000, s2_hw});
  assign hh_s = $signed({3'b000, s2_hh});

  always_comb begin
    push                = s2_valid;
    push_index          = s2_index;
    push_job.drop       = s2_drop;
    push_job.ent.left   = s2_cx - hw_s;
    push_job.ent.right  = s2_cx + hw_s;
    push_job.ent.top    = s2_cy - hh_s;
    push_job.ent.bottom = s2_cy + hh_s;
    push_job.ent.layer  = s2_layer;
    push_job.ent.mask   = s2_mask;
  end

endmodule

`default_nettype wire

### rtl/pac_queue.sv
// Two-entry job queue between the front end and the pair walker.
// No dependencies.
`default_nettype none

module pac_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             ready,
  output logic                  valid,
  output logic      [WIDTH-1:0] head_data
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;
  logic             do_pop;

  assign valid     = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign do_pop    = ready & valid;
  assign head_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= 2'(count + {1'b0, push} - {1'b0, do_pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

### rtl/pac_back.sv
// Pair walker: stores each new box that is not dropped and walks earlier entries one per cycle.
// Uses pac_pkg types and one pac_ram instance for the entry store.
`default_nettype none

module pac_back
  import pac_pkg::*;
#(
  parameter int MAX_COLLIDERS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  input  wire job_t                        q_job,
  input  wire logic [$clog2(MAX_COLLIDERS)-1:0] q_index,
  output logic                             q_ready,
  output logic                             result_valid,
  output logic [INDEX_W-1:0]               earlier_index,
  output logic [INDEX_W-1:0]               new_index,
  output logic                             earlier_hits_new,
  output logic                             new_hits_earlier,
  output logic                             dropped,
  output logic                             last
);

  localparam int AW = $clog2(MAX_COLLIDERS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN
  } state_t;

  state_t        state;
  entry_t        job;
  logic [AW-1:0] job_n;
  logic [AW-1:0] rd_idx;
  logic          rv;
  logic [AW-1:0] rv_idx;
  logic          pend_valid;
  logic [AW-1:0] pend_idx;
  logic          pend_ehn, pend_nhe;

  logic                      wr_en, rd_en;
  logic [$bits(entry_t)-1:0] rd_data;
  entry_t                    e;
  logic                      ehn, nhe, hit;

  assign q_ready = (state == S_IDLE);
  assign wr_en   = q_ready & q_valid & ~q_job.drop;
  assign rd_en   = (state == S_WALK);

  pac_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_COLLIDERS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (q_index),
    .wr_data (q_job.ent),
    .rd_en   (rd_en),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  assign e   = entry_t'(rd_data);
  assign ehn = |(e.mask & job.layer);
  assign nhe = |(job.mask & e.layer);
  assign hit = (ehn | nhe)
             && ($signed(e.left) < $signed(job.right))
             && ($signed(e.right) > $signed(job.left))
             && ($signed(e.top) < $signed(job.bottom))
             && ($signed(e.bottom) > $signed(job.top));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rv           <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      rv           <= (state == S_WALK);
      rv_idx       <= rd_idx;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            job        <= q_job.ent;
            job_n      <= q_index;
            rd_idx     <= '0;
            pend_valid <= 1'b0;
            if (q_job.drop) begin
              result_valid     <= 1'b1;
              earlier_index    <= '0;
              new_index        <= '0;
              earlier_hits_new <= 1'b0;
              new_hits_earlier <= 1'b0;
              dropped          <= 1'b1;
              last             <= 1'b1;
            end else if (q_index != '0) begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          rd_idx <= AW'(rd_idx + 1'b1);
          if (rd_idx == AW'(job_n - 1'b1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rv) begin
            if (pend_valid) begin
              result_valid     <= 1'b1;
              earlier_index    <= INDEX_W'(pend_idx);
              new_index        <= INDEX_W'(job_n);
              earlier_hits_new <= pend_ehn;
              new_hits_earlier <= pend_nhe;
              dropped          <= 1'b0;
              last             <= 1'b1;
            end
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // hold one hit back so the final one can carry last
      if (rv && hit) begin
        if (pend_valid) begin
          result_valid     <= 1'b1;
          earlier_index    <= INDEX_W'(pend_idx);
          new_index        <= INDEX_W'(job_n);
          earlier_hits_new <= pend_ehn;
          new_hits_earlier <= pend_nhe;
          dropped          <= 1'b0;
          last             <= 1'b0;
        end
        pend_valid <= 1'b1;
        pend_idx   <= rv_idx;
        pend_ehn   <= ehn;
        pend_nhe   <= nhe;
      end
    end
  end

  a_rv_after_walk: assert property (@(posedge clk) disable iff (rst)
    rv |-> $past(state) == S_WALK)
    else $error("read data flagged without a walk read");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> rd_idx < job_n)
    else $error("walk index past the new entry");

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> pend_idx < job_n)
    else $error("held hit does not precede the new entry");

  a_hit_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid && !dropped |-> earlier_hits_new || new_hits_earlier)
    else $error("pair result with neither direction flag");

  a_drop_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && dropped |-> last && !earlier_hits_new && !new_hits_earlier)
    else $error("dropped result malformed");

endmodule

`default_nettype wire

### rtl/pairwise_aabb_collision_core.sv
// Top level of the pairwise box collision core.
// Depends on pac_pkg, pac_front, pac_queue, pac_back and pac_ram.
`default_nettype none

// Usage:
//   Present one collider on the input ports with start high; it is taken at a
//   rising edge where start is high and busy is low. Set first_of_frame on the
//   first collider of a frame to empty the store before it is added.
//   The front end takes an item, forms its box in steps (multiply, center/half
//   size, edges) and queues it in a two-entry job queue; busy is high while
//   the front end holds an item or the queue is full.
//   The back end pops a job, writes its box into the entry RAM and walks the
//   n colliders stored earlier in the frame, one RAM read per cycle, with n
//   at most MAX_COLLIDERS - 1. It takes a new job only once it is back in
//   idle, so the RAM read port walk bounds the rate of a steady stream.
//   A collider that finds the store full gives a single dropped result in
//   the cycle after it is popped.
//   Each overlapping pair whose masks meet is shown for exactly one cycle
//   with result_valid high, in order of the earlier index; last marks the
//   final pair of a collider. An undropped collider with no hit gives no result.
//   The receiver cannot stall: results must be taken when shown.
//   Reset empties the store, the queue and the pipeline; entry RAM contents
//   need no clearing since only entries below the fill count are read.

module pairwise_aabb_collision_core
  import pac_pkg::*;
#(
  parameter int MAX_COLLIDERS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               first_of_frame,
  input  wire logic signed [23:0] pos_x,
  input  wire logic signed [23:0] pos_y,
  input  wire logic        [15:0] scale,
  input  wire logic signed [11:0] offset_x,
  input  wire logic signed [11:0] offset_y,
  input  wire logic        [11:0] box_width,
  input  wire logic        [11:0] box_height,
  input  wire logic        [15:0] layer,
  input  wire logic        [15:0] mask,
  output logic                    result_valid,
  output logic             [4:0]  earlier_index,
  output logic             [4:0]  new_index,
  output logic                    earlier_hits_new,
  output logic                    new_hits_earlier,
  output logic                    dropped,
  output logic                    last
);

  localparam int AW = $clog2(MAX_COLLIDERS);
  localparam int QW = $bits(job_t) + AW;

  // front to queue
  logic          q_full;
  logic          push;
  job_t          push_job;
  logic [AW-1:0] push_index;

  // queue to walker
  logic          q_valid;
  logic          q_ready;
  logic [QW-1:0] head_data;
  job_t          q_job;
  logic [AW-1:0] q_index;

  pac_front #(
    .MAX_COLLIDERS (MAX_COLLIDERS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .first_of_frame (first_of_frame),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .scale          (scale),
    .offset_x       (offset_x),
    .offset_y       (offset_y),
    .box_width      (box_width),
    .box_height     (box_height),
    .layer          (layer),
    .mask           (mask),
    .q_full         (q_full),
    .push           (push),
    .push_job       (push_job),
    .push_index     (push_index)
  );

  // Pack the job word with its store index for the queue.
  pac_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_job, push_index}),
    .full      (q_full),
    .ready     (q_ready),
    .valid     (q_valid),
    .head_data (head_data)
  );

  assign q_job   = job_t'(head_data[QW-1:AW]);
  assign q_index = head_data[AW-1:0];

  pac_back #(
    .MAX_COLLIDERS (MAX_COLLIDERS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_job            (q_job),
    .q_index          (q_index),
    .q_ready          (q_ready),
    .result_valid     (result_valid),
    .earlier_index    (earlier_index),
    .new_index        (new_index),
    .earlier_hits_new (earlier_hits_new),
    .new_hits_earlier (new_hits_earlier),
    .dropped          (dropped),
    .last             (last)
  );

endmodule

`default_nettype wire

### sim/tb_pairwise_aabb_collision_core.sv
// Self-checking bench for pairwise_aabb_collision_core: directed and clustered random colliders.
// Predicts every overlap pair in-bench and checks the result strobe stream.
// Depends only on the core RTL and its package.

module tb_pairwise_aabb_collision_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_COLLIDERS  = 32;
  localparam int RANDOM_ITEMS   = 240;
  // A collider walks at most MAX_COLLIDERS - 1 earlier entries; the tail covers that walk and the pipeline.
  localparam int TAIL_CYCLES    = 2 * MAX_COLLIDERS + 16;

  typedef struct {
    logic               first_of_frame;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic        [15:0] scale;
    logic signed [11:0] offset_x;
    logic signed [11:0] offset_y;
    logic        [11:0] box_width;
    logic        [11:0] box_height;
    logic        [15:0] layer;
    logic        [15:0] mask;
  } collider_t;

  typedef struct {
    collider_t c;
    int        idle_pct;   // chance in percent of leaving a cycle empty before this word
    bit        drain;      // hold this word until every pending pair has come out
  } send_word_t;

  typedef struct {
    logic [4:0] earlier_index;
    logic [4:0] new_index;
    logic       earlier_hits_new;
    logic       new_hits_earlier;
    logic       dropped;
    logic       last;
  } pair_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               start          = 1'b0;
  logic               first_of_frame = 1'b0;
  logic signed [23:0] pos_x          = '0;
  logic signed [23:0] pos_y          = '0;
  logic        [15:0] scale          = '0;
  logic signed [11:0] offset_x       = '0;
  logic signed [11:0] offset_y       = '0;
  logic        [11:0] box_width      = '0;
  logic        [11:0] box_height     = '0;
  logic        [15:0] layer          = '0;
  logic        [15:0] mask           = '0;

  logic       busy;
  logic       result_valid;
  logic [4:0] earlier_index;
  logic [4:0] new_index;
  logic       earlier_hits_new;
  logic       new_hits_earlier;
  logic       dropped;
  logic       last;

  send_word_t   words_to_send[$];
  pair_result_t expected_pairs[$];
  logic         all_pairs_seen = 1'b1;   // registered: no expected pair outstanding
  bit           drain_armed = 1'b0;
  int           mismatch_count = 0;

  // Shadow copy of the collider store, as seen from outside.
  longint       shadow_left[MAX_COLLIDERS];
  longint       shadow_right[MAX_COLLIDERS];
  longint       shadow_top[MAX_COLLIDERS];
  longint       shadow_bottom[MAX_COLLIDERS];
  logic  [15:0] shadow_layer[MAX_COLLIDERS];
  logic  [15:0] shadow_mask[MAX_COLLIDERS];
  int           shadow_count = 0;

  pairwise_aabb_collision_core #(
    .MAX_COLLIDERS(MAX_COLLIDERS)
  ) i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .first_of_frame   (first_of_frame),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .scale            (scale),
    .offset_x         (offset_x),
    .offset_y         (offset_y),
    .box_width        (box_width),
    .box_height       (box_height),
    .layer            (layer),
    .mask             (mask),
    .result_valid     (result_valid),
    .earlier_index    (earlier_index),
    .new_index        (new_index),
    .earlier_hits_new (earlier_hits_new),
    .new_hits_earlier (new_hits_earlier),
    .dropped          (dropped),
    .last             (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic collider_t make_collider(input bit first, input int px, input int py,
                                              input int sc, input int ox, input int oy,
                                              input int wd, input int ht,
                                              input int lay, input int msk);
    collider_t c;
    c.first_of_frame = first;
    c.pos_x          = px[23:0];
    c.pos_y          = py[23:0];
    c.scale          = sc[15:0];
    c.offset_x       = ox[11:0];
    c.offset_y       = oy[11:0];
    c.box_width      = wd[11:0];
    c.box_height     = ht[11:0];
    c.layer          = lay[15:0];
    c.mask           = msk[15:0];
    return c;
  endfunction

  task automatic queue_collider(input collider_t c, input int idle_pct, input bit drain);
    send_word_t w;
    w.c        = c;
    w.idle_pct = idle_pct;
    w.drain    = drain;
    words_to_send = {words_to_send, w};
  endtask

  // Form the box of an accepted collider, test it against the shadow store in
  // index order and queue one expected pair per overlap. Store the box last.
  function automatic void predict_collider(input collider_t c);
    longint       px, py, sc, ox, oy, wd, ht;
    longint       cx, cy, hw, hh;
    longint       lf, rt, tp, bt;
    bit           ehn, nhe;
    int           first_new;
    pair_result_t hit;
    px = c.pos_x;
    py = c.pos_y;
    sc = c.scale;
    ox = c.offset_x;
    oy = c.offset_y;
    wd = c.box_width;
    ht = c.box_height;
    first_new = expected_pairs.size();
    if (c.first_of_frame) shadow_count = 0;
    // Full store: drop the collider and flag it once, last set, all other fields zero.
    if (shadow_count >= MAX_COLLIDERS) begin
      hit = '{earlier_index: '0, new_index: '0, earlier_hits_new: 1'b0,
              new_hits_earlier: 1'b0, dropped: 1'b1, last: 1'b1};
      expected_pairs = {expected_pairs, hit};
      return;
    end
    // Signed division truncates toward zero, as the Q8 center math needs.
    cx = (px + ox * sc) / 256;
    cy = (py + oy * sc) / 256;
    hw = ((sc * wd) / 256) / 2;
    hh = ((sc * ht) / 256) / 2;
    lf = cx - hw;
    rt = cx + hw;
    tp = cy - hh;
    bt = cy + hh;
    for (int i = 0; i < shadow_count; i++) begin
      ehn = |(shadow_mask[i] & c.layer);
      nhe = |(c.mask & shadow_layer[i]);
      // Skip pairs with disjoint masks; overlap needs strict inequalities.
      if ((ehn || nhe) && shadow_left[i] < rt && shadow_right[i] > lf &&
          shadow_top[i] < bt && shadow_bottom[i] > tp) begin
        hit = '{earlier_index: 5'(i), new_index: 5'(shadow_count), earlier_hits_new: ehn,
                new_hits_earlier: nhe, dropped: 1'b0, last: 1'b0};
        expected_pairs = {expected_pairs, hit};
      end
    end
    if (expected_pairs.size() > first_new) expected_pairs[$].last = 1'b1;
    shadow_left[shadow_count]   = lf;
    shadow_right[shadow_count]  = rt;
    shadow_top[shadow_count]    = tp;
    shadow_bottom[shadow_count] = bt;
    shadow_layer[shadow_count]  = c.layer;
    shadow_mask[shadow_count]   = c.mask;
    shadow_count++;
  endfunction

  // Driver: present the next word once the slot is free, i.e. nothing is
  // shown or the shown word is taken at this edge. Hold a word while busy.
  always @(posedge clk) begin : driver
    send_word_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (words_to_send.size() == 0) begin
        start <= 1'b0;
      end else if (words_to_send[0].drain && !drain_armed) begin
        // Arm the pause; the outstanding flag is valid from the next edge on.
        drain_armed = 1'b1;
        start <= 1'b0;
      end else if (drain_armed && !all_pairs_seen) begin
        start <= 1'b0;
      end else if ($urandom_range(99) < words_to_send[0].idle_pct) begin
        start <= 1'b0;
      end else begin
        nxt = words_to_send.pop_front();
        drain_armed = 1'b0;
        start          <= 1'b1;
        first_of_frame <= nxt.c.first_of_frame;
        pos_x          <= nxt.c.pos_x;
        pos_y          <= nxt.c.pos_y;
        scale          <= nxt.c.scale;
        offset_x       <= nxt.c.offset_x;
        offset_y       <= nxt.c.offset_y;
        box_width      <= nxt.c.box_width;
        box_height     <= nxt.c.box_height;
        layer          <= nxt.c.layer;
        mask           <= nxt.c.mask;
      end
    end
  end

  // Monitor: check each strobed pair against the oldest expectation, then
  // predict for a word accepted at this edge. All reads see pre-edge values.
  always @(posedge clk) begin : monitor
    collider_t    seen;
    pair_result_t want;
    if (!rst) begin
      if (result_valid) begin
        if (expected_pairs.size() == 0) begin
          report_mismatch($sformatf("pair %0d/%0d with nothing expected",
                                    earlier_index, new_index));
        end else begin
          want = expected_pairs.pop_front();
          if (earlier_index !== want.earlier_index)
            report_mismatch($sformatf("earlier_index got %0d want %0d",
                                      earlier_index, want.earlier_index));
          if (new_index !== want.new_index)
            report_mismatch($sformatf("new_index got %0d want %0d",
                                      new_index, want.new_index));
          if (earlier_hits_new !== want.earlier_hits_new)
            report_mismatch($sformatf("earlier_hits_new got %b want %b (pair %0d/%0d)",
                                      earlier_hits_new, want.earlier_hits_new,
                                      want.earlier_index, want.new_index));
          if (new_hits_earlier !== want.new_hits_earlier)
            report_mismatch($sformatf("new_hits_earlier got %b want %b (pair %0d/%0d)",
                                      new_hits_earlier, want.new_hits_earlier,
                                      want.earlier_index, want.new_index));
          if (dropped !== want.dropped)
            report_mismatch($sformatf("dropped got %b want %b", dropped, want.dropped));
          if (last !== want.last)
            report_mismatch($sformatf("last got %b want %b (pair %0d/%0d)",
                                      last, want.last, want.earlier_index, want.new_index));
        end
      end
      if (start && !busy) begin
        seen.first_of_frame = first_of_frame;
        seen.pos_x          = pos_x;
        seen.pos_y          = pos_y;
        seen.scale          = scale;
        seen.offset_x       = offset_x;
        seen.offset_y       = offset_y;
        seen.box_width      = box_width;
        seen.box_height     = box_height;
        seen.layer          = layer;
        seen.mask           = mask;
        predict_collider(seen);
      end
    end
    all_pairs_seen <= (expected_pairs.size() == 0);
  end

  // Stimulus: fill the send queue, release reset, then wait for the drain.
  initial begin : stimulus
    int sent;
    int frame_no;
    int frame_len;
    int idle_pct;
    int cluster_x, cluster_y;
    int sc, lay, msk;
    collider_t c;

    // Directed: basic overlap, touching edges, one-way and disjoint masks.
    queue_collider(make_collider(1, 0, 0, 256, 0, 0, 100, 100, 16'h0001, 16'h0001), 0, 0);
    queue_collider(make_collider(0, 20*256, 10*256, 256, 0, 0, 100, 100,
                                 16'h0001, 16'h0001), 0, 0);
    // Right edge of the first box equals the left edge of this one: no overlap there.
    queue_collider(make_collider(0, 100*256, 0, 256, 0, 0, 100, 100,
                                 16'h0001, 16'h0001), 0, 0);
    queue_collider(make_collider(0, 0, 0, 256, 0, 0, 40, 40, 16'h0002, 16'h0002), 0, 0);
    queue_collider(make_collider(0, 0, 0, 256, 0, 0, 40, 40, 16'h0002, 16'h0001), 0, 0);
    // Zero scale collapses to a point; two points at one place never overlap.
    queue_collider(make_collider(0, 0, 0, 0, 5, 5, 100, 100, 16'h0001, 16'h0001), 0, 0);
    queue_collider(make_collider(0, 0, 0, 0, 0, 0, 4095, 4095, 16'h0001, 16'h0001), 0, 0);
    queue_collider(make_collider(0, 0, 0, 256, 0, 0, 0, 50, 16'h0001, 16'h0001), 0, 0);
    // Negative sums truncate toward zero.
    queue_collider(make_collider(0, -1, -255, 256, -3, 7, 1, 3, 16'h0001, 16'h0001), 0, 0);
    queue_collider(make_collider(0, -300*256, 0, 512, 100, -100, 50, 50,
                                 16'hFFFF, 16'hFFFF), 0, 0);
    // Field extremes.
    queue_collider(make_collider(0, 8388607, 8388607, 65535, 2047, 2047, 4095, 4095,
                                 16'hFFFF, 16'hFFFF), 0, 0);
    queue_collider(make_collider(0, -8388608, -8388608, 65535, -2048, -2048, 4095, 4095,
                                 16'hFFFF, 16'hFFFF), 0, 0);
    queue_collider(make_collider(0, 0, 0, 256, 0, 0, 100, 100, 16'h0000, 16'h0000), 0, 0);
    // Frame restart in mid-stream, then a one-way hit.
    queue_collider(make_collider(1, 0, 0, 256, 0, 0, 100, 100, 16'h8000, 16'h8000), 0, 0);
    queue_collider(make_collider(0, 0, 0, 256, 0, 0, 100, 100, 16'h8000, 16'h0000), 0, 0);
    queue_collider(make_collider(1, 0, 0, 256, 0, 0, 100, 100, 16'h8000, 16'h8000), 0, 0);

    // Random: frames of clustered colliders, a few long enough to fill the
    // store, with some noise words of full-range fields mixed in.
    sent     = 0;
    frame_no = 0;
    while (sent < RANDOM_ITEMS) begin
      // Force the first frame past capacity so the full-store path is hit early.
      if (frame_no == 0 || $urandom_range(9) == 0)
        frame_len = $urandom_range(MAX_COLLIDERS + 4, MAX_COLLIDERS + 1);
      else
        frame_len = $urandom_range(14, 1);
      cluster_x = int'($urandom_range(4000)) - 2000;
      cluster_y = int'($urandom_range(4000)) - 2000;
      for (int k = 0; k < frame_len; k++) begin
        // Idle phases: none, heavy, none, light.
        if (sent < RANDOM_ITEMS / 4)          idle_pct = 0;
        else if (sent < RANDOM_ITEMS / 2)     idle_pct = 80;
        else if (sent < 3 * RANDOM_ITEMS / 4) idle_pct = 0;
        else                                  idle_pct = 12;
        if (frame_no != 0 && $urandom_range(99) < 12) begin
          c = make_collider(1'($urandom_range(1)), int'($urandom), int'($urandom),
                            $urandom_range(65535), int'($urandom), int'($urandom),
                            $urandom_range(4095), $urandom_range(4095),
                            $urandom_range(65535), $urandom_range(65535));
        end else begin
          case ($urandom_range(7))
            0:       sc = 0;
            1, 2, 3: sc = 256;
            default: sc = $urandom_range(1024, 32);
          endcase
          // Few layer bits so that masks meet often, now and then none at all.
          lay = (1 << $urandom_range(3)) | (($urandom_range(3) == 0) ? 16'h0010 : 0);
          msk = ($urandom_range(9) == 0) ? 0 : (1 << $urandom_range(3));
          if ($urandom_range(3) == 0) msk = msk | (1 << $urandom_range(3));
          c = make_collider(k == 0,
                            (cluster_x + int'($urandom_range(600)) - 300) * 256
                              + int'($urandom_range(255)),
                            (cluster_y + int'($urandom_range(600)) - 300) * 256
                              - int'($urandom_range(255)),
                            sc, int'($urandom_range(128)) - 64,
                            int'($urandom_range(128)) - 64,
                            $urandom_range(300), $urandom_range(300), lay, msk);
        end
        // Pause for a full drain at the start of the random part and midway.
        queue_collider(c, idle_pct, sent == 0 || sent == RANDOM_ITEMS / 2);
        sent++;
      end
      frame_no++;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Sample on the falling edge so the queues and start have settled.
    @(negedge clk);
    while (words_to_send.size() != 0 || start || expected_pairs.size() != 0)
      @(negedge clk);
    // Let any collider still walking finish and catch stray results.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/pac_pkg.sv
rtl/pac_ram.sv
rtl/pac_front.sv
rtl/pac_queue.sv
rtl/pac_back.sv
rtl/pairwise_aabb_collision_core.sv
sim/tb_pairwise_aabb_collision_core.sv
